>>> rtl/rsr_pkg.sv
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared constants, row layout and request bundle of the replacement engine.
// ----------------------------------------------------------------------------
package rsr_pkg;

   localparam int SETS        = 2048;
   localparam int SET_BITS    = $clog2(SETS);
   localparam int WAYS        = 16;
   localparam int WAY_BITS    = 4;
   localparam int SIG_BITS    = 6;
   localparam int SIG_COUNT   = 1 << SIG_BITS;
   localparam int LEADER_SETS = 64;
   localparam int DUEL_BITS   = 10;
   localparam int ADDR_BITS   = 48;
   localparam int STRIDE_BITS = ADDR_BITS + 1;
   localparam int MASK_BITS   = 16;
   localparam int CHANCE_BITS = 5;

   localparam logic [DUEL_BITS-1:0] DUEL_MID = DUEL_BITS'(1 << (DUEL_BITS - 1));
   localparam logic [DUEL_BITS-1:0] DUEL_MAX = '1;

   localparam logic [1:0] RRPV_NEAR    = 2'd0;
   localparam logic [1:0] RRPV_LONG    = 2'd2;
   localparam logic [1:0] RRPV_DISTANT = 2'd3;
   localparam logic [1:0] OUTCOME_INIT = 2'd1;
   localparam logic [1:0] OUTCOME_MAX  = 2'd3;
   localparam logic [1:0] OUTCOME_HOT  = 2'd2;
   localparam logic [1:0] LEVEL_MAX    = 2'd3;
   localparam logic [1:0] LEVEL_STREAM = 2'd2;

   localparam logic KIND_VICTIM = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   typedef struct packed {
      logic [WAYS-1:0][1:0]          rrpv;
      logic [WAYS-1:0][SIG_BITS-1:0] sig;
      logic [SIG_COUNT-1:0][1:0]     outcome;
      logic [ADDR_BITS-1:0]          prior_addr;
      logic [STRIDE_BITS-1:0]        prior_stride;
      logic [1:0]                    level;
   } row_type;

   typedef struct packed {
      logic                   kind;
      logic [SET_BITS-1:0]    set_index;
      logic [WAY_BITS-1:0]    way;
      logic [MASK_BITS-1:0]   valid_mask;
      logic [ADDR_BITS-1:0]   paddr;
      logic [ADDR_BITS-1:0]   pc;
      logic                   hit;
      logic [CHANCE_BITS-1:0] chance;
   } req_type;

   function automatic row_type reset_row();
      row_type r;
      for (int i = 0; i < WAYS; i++) begin
         r.rrpv[i] = RRPV_DISTANT;
         r.sig[i]  = '0;
      end
      for (int i = 0; i < SIG_COUNT; i++) begin
         r.outcome[i] = OUTCOME_INIT;
      end
      r.prior_addr   = '0;
      r.prior_stride = '0;
      r.level        = '0;
      return r;
   endfunction

endpackage

>>> rtl/rsr_row_store.sv
// ----------------------------------------------------------------------------
// rsr_row_store
// Per-set row memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rsr_row_store (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [rsr_pkg::SET_BITS-1:0] wr_addr,
   input  rsr_pkg::row_type         wr_data,
   input  logic                     rd_en,
   input  logic [rsr_pkg::SET_BITS-1:0] rd_addr,
   output rsr_pkg::row_type         rd_data
);
   import rsr_pkg::*;

   row_type mem [SETS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rsr_row_update.sv
// ----------------------------------------------------------------------------
// rsr_row_update
// Modify stage: victim choice with ageing, hit promotion, stride tracking,
// fill insertion depth and duel counter update.
// ----------------------------------------------------------------------------
module rsr_row_update (
   input  rsr_pkg::row_type              row_in,
   input  rsr_pkg::req_type              req,
   input  logic [rsr_pkg::DUEL_BITS-1:0] duel_in,
   output rsr_pkg::row_type              row_out,
   output logic                          wr_en,
   output logic [rsr_pkg::WAY_BITS-1:0]  victim_way,
   output logic [rsr_pkg::DUEL_BITS-1:0] duel_out
);
   import rsr_pkg::*;

   logic                   has_inv;
   logic [1:0]             top;
   logic                   any3, any2, any1;
   logic [1:0]             aged;
   logic [STRIDE_BITS-1:0] stride;
   logic                   match;
   logic [1:0]             level;
   logic [SIG_BITS-1:0]    sig;
   logic [SIG_BITS-1:0]    old_sig;
   logic [1:0]             oc;
   logic                   lead_s, lead_b;
   logic [1:0]             bimodal;
   logic [1:0]             depth;
   logic [DUEL_BITS-1:0]   duel_tmp;

   always_comb begin
      row_out    = row_in;
      wr_en      = 1'b0;
      victim_way = '0;
      duel_out   = duel_in;
      has_inv    = 1'b0;
      any3       = 1'b0;
      any2       = 1'b0;
      any1       = 1'b0;
      top        = '0;
      aged       = '0;
      stride     = '0;
      match      = 1'b0;
      level      = row_in.level;
      sig        = req.pc[SIG_BITS-1:0] ^ req.pc[SIG_BITS+7:8];
      old_sig    = row_in.sig[req.way];
      oc         = '0;
      lead_s     = req.set_index < SET_BITS'(LEADER_SETS);
      lead_b     = req.set_index >= SET_BITS'(SETS - LEADER_SETS);
      bimodal    = (req.chance == '0) ? RRPV_LONG : RRPV_DISTANT;
      depth      = RRPV_LONG;
      duel_tmp   = duel_in;

      if (req.kind == KIND_VICTIM) begin
         for (int i = WAYS - 1; i >= 0; i--) begin
            if (!req.valid_mask[i]) begin
               victim_way = WAY_BITS'(i);
               has_inv    = 1'b1;
            end
         end
         if (!has_inv) begin
            for (int i = 0; i < WAYS; i++) begin
               any3 = any3 | (row_in.rrpv[i] == 2'd3);
               any2 = any2 | (row_in.rrpv[i] == 2'd2);
               any1 = any1 | (row_in.rrpv[i] == 2'd1);
            end
            top = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
            for (int i = WAYS - 1; i >= 0; i--) begin
               aged            = row_in.rrpv[i] + (RRPV_DISTANT - top);
               row_out.rrpv[i] = aged;
               if (aged == RRPV_DISTANT) begin
                  victim_way = WAY_BITS'(i);
               end
            end
            wr_en = 1'b1;
         end
      end else begin
         wr_en  = 1'b1;
         // stride detector
         stride = {1'b0, req.paddr} - {1'b0, row_in.prior_addr};
         match  = (row_in.prior_addr != '0) && (stride == row_in.prior_stride);
         if (match) begin
            if (level != LEVEL_MAX) level = level + 2'd1;
         end else begin
            if (level != 2'd0) level = level - 2'd1;
         end
         row_out.level        = level;
         row_out.prior_stride = stride;
         row_out.prior_addr   = req.paddr;

         if (req.hit) begin
            row_out.rrpv[req.way] = RRPV_NEAR;
            if (row_in.outcome[old_sig] != OUTCOME_MAX) begin
               row_out.outcome[old_sig] = row_in.outcome[old_sig] + 2'd1;
            end
         end else begin
            oc = row_in.outcome[sig];
            if (oc >= OUTCOME_HOT) depth = RRPV_NEAR;
            if (level >= LEVEL_STREAM) depth = RRPV_DISTANT;
            priority if (lead_s) begin
               depth = RRPV_LONG;
            end else if (lead_b) begin
               depth = bimodal;
            end else if (level < LEVEL_STREAM && oc < OUTCOME_HOT) begin
               depth = (duel_in >= DUEL_MID) ? bimodal : RRPV_LONG;
            end
            row_out.rrpv[req.way] = depth;
            row_out.sig[req.way]  = sig;
            if (lead_s && depth == RRPV_LONG && duel_tmp != DUEL_MAX) begin
               duel_tmp = duel_tmp + 1'b1;
            end
            if (lead_b && depth >= RRPV_LONG && duel_tmp != '0) begin
               duel_tmp = duel_tmp - 1'b1;
            end
            duel_out = duel_tmp;
            if (oc != 2'd0 && depth == RRPV_DISTANT) begin
               row_out.outcome[sig] = oc - 2'd1;
            end
         end
      end
   end

endmodule

>>> rtl/rrip_ship_stream_replacement.sv
// ----------------------------------------------------------------------------
// rrip_ship_stream_replacement
// Cache replacement engine: 2-bit re-reference values, per-set signature
// counters, stride streaming detector and set duelling.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// req       in         req_valid/req_ready   kind, set_index, way, valid_mask,
//                                            paddr, pc, hit, chance
// rsp       out        rsp_valid/rsp_ready   victim_way (victim requests only)
//
// each request is a row read from the set memory, then a modify and write back in
// the same memory, one request in flight at a time
// after reset a clearing pass initialises every one of the 2048 set rows;
// no request is taken until it ends
// a victim result waits in an output register; the modify step holds only
// when that register is still full
// ----------------------------------------------------------------------------
module rrip_ship_stream_replacement (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [10:0]                        req_set_index,
   input  logic [3:0]                         req_way,
   input  logic [15:0]                        req_valid_mask,
   input  logic [47:0]                        req_paddr,
   input  logic [47:0]                        req_pc,
   input  logic                               req_hit,
   input  logic [4:0]                         req_chance,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [3:0]                         rsp_victim_way
);
   import rsr_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_MODIFY = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [SET_BITS-1:0]  clr_cnt_ff, clr_cnt_in;
   req_type              req_ff, req_in;
   logic [DUEL_BITS-1:0] duel_ff, duel_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WAY_BITS-1:0]  rsp_way_ff, rsp_way_in;

   logic                 accept;
   logic                 go;
   logic                 mem_wr_en;
   logic [SET_BITS-1:0]  mem_wr_addr;
   row_type              mem_wr_data;
   row_type              rd_row;
   row_type              new_row;
   logic                 upd_wr_en;
   logic [WAY_BITS-1:0]  upd_victim;
   logic [DUEL_BITS-1:0] upd_duel;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign go        = (state_ff == ST_MODIFY) &&
                      !(req_ff.kind == KIND_VICTIM && rsp_valid_ff && !rsp_ready);

   rsr_row_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (accept),
      .rd_addr (req_set_index),
      .rd_data (rd_row)
   );

   rsr_row_update u_update (
      .row_in     (rd_row),
      .req        (req_ff),
      .duel_in    (duel_ff),
      .row_out    (new_row),
      .wr_en      (upd_wr_en),
      .victim_way (upd_victim),
      .duel_out   (upd_duel)
   );

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = req_ff.set_index;
      mem_wr_data = new_row;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_cnt_ff;
         mem_wr_data = reset_row();
      end else if (go) begin
         mem_wr_en = upd_wr_en;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      req_in       = req_ff;
      duel_in      = duel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_way_in   = rsp_way_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SET_BITS'(SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               req_in.kind       = req_kind;
               req_in.set_index  = req_set_index;
               req_in.way        = req_way;
               req_in.valid_mask = req_valid_mask;
               req_in.paddr      = req_paddr;
               req_in.pc         = req_pc;
               req_in.hit        = req_hit;
               req_in.chance     = req_chance;
               state_in          = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            if (go) begin
               duel_in  = upd_duel;
               state_in = ST_IDLE;
               if (req_ff.kind == KIND_VICTIM) begin
                  rsp_valid_in = 1'b1;
                  rsp_way_in   = upd_victim;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         duel_ff      <= DUEL_MID;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         duel_ff      <= duel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_way_ff <= rsp_way_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;

endmodule

>>> rtl/rsr_checker.sv
// ----------------------------------------------------------------------------
// rsr_port_checks
// Port-level checks of the replacement engine, bound to the top level.
// ----------------------------------------------------------------------------
module rsr_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic [15:0] req_valid_mask,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_victim_way
);
   import rsr_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_victim_way))
      else $error("result changed while stalled");

   // one request in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a victim request with way 0 invalid, taken with no result pending, returns way 0
   a_inv0: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_VICTIM && !req_valid_mask[0] && !rsp_valid
      |-> ##2 (rsp_valid && rsp_victim_way == '0))
      else $error("wrong victim for invalid way");

   // updates give no result
   a_upd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_UPDATE && !rsp_valid |-> ##2 !rsp_valid)
      else $error("result after update");

endmodule

bind rrip_ship_stream_replacement rsr_port_checks u_rsr_port_checks (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_kind       (req_kind),
   .req_valid_mask (req_valid_mask),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_victim_way (rsp_victim_way)
);

>>> dv/rsr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsr_checker
// Watches the request and result channels of the replacement engine, keeps a
// shadow copy of every set and predicts each victim way, comparing results in
// order and counting failures.
// ----------------------------------------------------------------------------
module rsr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_kind,
   input  logic [10:0] req_set_index,
   input  logic [3:0]  req_way,
   input  logic [15:0] req_valid_mask,
   input  logic [47:0] req_paddr,
   input  logic [47:0] req_pc,
   input  logic        req_hit,
   input  logic [4:0]  req_chance,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [3:0]  rsp_victim_way,
   output int          fail_count,
   output int          pending_count
);
   import rsr_pkg::*;

   logic [1:0]             shadow_rrpv    [SETS][WAYS];
   logic [SIG_BITS-1:0]    shadow_sig     [SETS][WAYS];
   logic [1:0]             shadow_outcome [SETS][SIG_COUNT];
   logic [ADDR_BITS-1:0]   shadow_addr    [SETS];
   logic [STRIDE_BITS-1:0] shadow_stride  [SETS];
   logic [1:0]             shadow_level   [SETS];
   logic [DUEL_BITS-1:0]   shadow_duel;
   logic [3:0]             victim_queue   [$];

   assign pending_count = victim_queue.size();

   function automatic logic [3:0] pick_victim(input int s, input logic [15:0] mask);
      logic [1:0] top;
      top = '0;
      for (int i = 0; i < WAYS; i++)
         if (!mask[i]) return 4'(i);
      for (int i = 0; i < WAYS; i++)
         if (shadow_rrpv[s][i] > top) top = shadow_rrpv[s][i];
      for (int i = 0; i < WAYS; i++)
         shadow_rrpv[s][i] = shadow_rrpv[s][i] + (RRPV_DISTANT - top);
      for (int i = 0; i < WAYS; i++)
         if (shadow_rrpv[s][i] == RRPV_DISTANT) return 4'(i);
      return '0;
   endfunction

   task automatic apply_update(input int s, input int w, input logic [47:0] addr,
                               input logic [47:0] pc, input logic hit,
                               input logic [4:0] chance);
      logic [STRIDE_BITS-1:0] stride;
      logic [SIG_BITS-1:0]    sig;
      logic [1:0]             depth, bimodal;
      logic                   lead_s, lead_b;
      stride = {1'b0, addr} - {1'b0, shadow_addr[s]};
      if (shadow_addr[s] != 0 && stride == shadow_stride[s]) begin
         if (shadow_level[s] < LEVEL_MAX) shadow_level[s]++;
      end else if (shadow_level[s] > 0) begin
         shadow_level[s]--;
      end
      shadow_stride[s] = stride;
      shadow_addr[s]   = addr;
      sig    = SIG_BITS'(pc ^ (pc >> 8));
      lead_s = s < LEADER_SETS;
      lead_b = s + LEADER_SETS >= SETS;
      bimodal = (chance == 0) ? RRPV_LONG : RRPV_DISTANT;
      if (hit) begin
         shadow_rrpv[s][w] = RRPV_NEAR;
         if (shadow_outcome[s][shadow_sig[s][w]] < OUTCOME_MAX)
            shadow_outcome[s][shadow_sig[s][w]]++;
         return;
      end
      depth = RRPV_LONG;
      if (shadow_outcome[s][sig] >= OUTCOME_HOT) depth = RRPV_NEAR;
      if (shadow_level[s] >= LEVEL_STREAM) depth = RRPV_DISTANT;
      if (lead_s) depth = RRPV_LONG;
      else if (lead_b) depth = bimodal;
      else if (shadow_level[s] < LEVEL_STREAM && shadow_outcome[s][sig] < OUTCOME_HOT)
         depth = (shadow_duel >= DUEL_MID) ? bimodal : RRPV_LONG;
      shadow_rrpv[s][w] = depth;
      shadow_sig[s][w]  = sig;
      if (lead_s && depth == RRPV_LONG && shadow_duel < DUEL_MAX) shadow_duel++;
      if (lead_b && depth >= RRPV_LONG && shadow_duel > 0) shadow_duel--;
      if (shadow_outcome[s][sig] > 0 && depth == RRPV_DISTANT) shadow_outcome[s][sig]--;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) begin
               shadow_rrpv[s][w] = RRPV_DISTANT;
               shadow_sig[s][w]  = '0;
            end
            for (int g = 0; g < SIG_COUNT; g++) shadow_outcome[s][g] = OUTCOME_INIT;
            shadow_addr[s]   = '0;
            shadow_stride[s] = '0;
            shadow_level[s]  = '0;
         end
         shadow_duel = DUEL_MID;
         victim_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (victim_queue.size() == 0) begin
               $error("unexpected result victim_way %0d", rsp_victim_way);
               fail_count++;
            end else begin
               logic [3:0] want;
               want = victim_queue.pop_front();
               if (rsp_victim_way !== want) begin
                  $error("victim_way expected %0d actual %0d", want, rsp_victim_way);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_VICTIM)
               victim_queue = {victim_queue, pick_victim(req_set_index, req_valid_mask)};
            else
               apply_update(req_set_index, req_way, req_paddr, req_pc, req_hit,
                            req_chance);
         end
      end
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random victim and update requests into the replacement
// engine with random gaps and result back-pressure, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import rsr_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic        clock, reset;
   logic        req_valid, req_ready, req_kind, req_hit;
   logic [10:0] req_set_index;
   logic [3:0]  req_way, rsp_victim_way;
   logic [15:0] req_valid_mask;
   logic [47:0] req_paddr, req_pc;
   logic [4:0]  req_chance;
   logic        rsp_valid, rsp_ready;
   int          fail_count, pending_count, idle_cycles;
   bit          hold_long;
   logic [47:0] stream_base [4];

   rrip_ship_stream_replacement u_dut (.*);

   rsr_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(input logic kind, input logic [10:0] s, input logic [3:0] w,
                       input logic [15:0] mask, input logic [47:0] addr,
                       input logic [47:0] pc, input logic hit, input logic [4:0] ch);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_set_index  <= s;
      req_way        <= w;
      req_valid_mask <= mask;
      req_paddr      <= addr;
      req_pc         <= pc;
      req_hit        <= hit;
      req_chance     <= ch;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_request(input bit busy);
      logic [10:0] s;
      int r;
      int g;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: s = 11'($urandom_range(0, 63));
         1: s = 11'($urandom_range(1984, 2047));
         2: s = 11'($urandom_range(0, 3) + 100);
         default: s = 11'($urandom);
      endcase
      if (r < 35)
         send(KIND_VICTIM, s, 4'($urandom), ($urandom_range(0, 3) == 0) ?
              16'($urandom) : 16'hffff, 48'({$urandom, $urandom}),
              48'({$urandom, $urandom}), 1'($urandom), 5'($urandom));
      else if (r < 60) begin
         stream_base[s[1:0]] = stream_base[s[1:0]] + 48'h40;
         send(KIND_UPDATE, s, 4'($urandom), 16'($urandom), stream_base[s[1:0]],
              48'($urandom_range(0, 7)), 1'($urandom_range(0, 3) == 0),
              5'($urandom_range(0, 3)));
      end else
         send(KIND_UPDATE, s, 4'($urandom), 16'($urandom), 48'({$urandom, $urandom}),
              48'({$urandom, $urandom}) & ((r & 1) ? 48'hff : '1), 1'($urandom),
              5'($urandom));
      g = gap_len();
      if (!busy && g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // result side back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_long = 0;
         end else if ($urandom_range(0, 40) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 9) < 7);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      hold_long = 0;
      idle_cycles = 0;
      req_valid = 0; req_kind = 0; req_set_index = 0; req_way = 0;
      req_valid_mask = 0; req_paddr = 0; req_pc = 0; req_hit = 0; req_chance = 0;
      foreach (stream_base[i]) stream_base[i] = 48'h1000 * (i + 1);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // directed: invalid ways, full sets, hits, fills in leader/follower sets
      send(KIND_VICTIM, 11'd5, 4'd0, 16'h0000, 48'h0, 48'h0, 1'b0, 5'd0);
      send(KIND_VICTIM, 11'd5, 4'd0, 16'h7fff, 48'h0, 48'h0, 1'b0, 5'd0);
      send(KIND_VICTIM, 11'd5, 4'd0, 16'hffff, 48'h0, 48'h0, 1'b0, 5'd0);
      send(KIND_UPDATE, 11'd5, 4'd15, 16'h0, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff,
           1'b0, 5'd31);
      send(KIND_UPDATE, 11'd5, 4'd15, 16'h0, 48'h0, 48'hffff_ffff_ffff, 1'b1, 5'd0);
      send(KIND_VICTIM, 11'd5, 4'd0, 16'hffff, 48'h0, 48'h0, 1'b0, 5'd0);
      for (int i = 0; i < 4; i++)
         send(KIND_UPDATE, 11'd1000, 4'(i), 16'h0, 48'h100 * (i + 1), 48'h3, 1'b0,
              5'(i));
      send(KIND_VICTIM, 11'd1000, 4'd0, 16'hffff, 48'h0, 48'h0, 1'b0, 5'd0);
      send(KIND_UPDATE, 11'd0, 4'd2, 16'h0, 48'h80, 48'h11, 1'b0, 5'd0);
      send(KIND_UPDATE, 11'd2047, 4'd3, 16'h0, 48'h80, 48'h11, 1'b0, 5'd0);
      send(KIND_UPDATE, 11'd2047, 4'd4, 16'h0, 48'h90, 48'h11, 1'b0, 5'd31);
      send(KIND_UPDATE, 11'd2047, 4'd4, 16'h0, 48'h90, 48'h11, 1'b1, 5'd31);
      send(KIND_VICTIM, 11'd2047, 4'd0, 16'hffff, 48'h0, 48'h0, 1'b0, 5'd0);
      send(KIND_VICTIM, 11'd0, 4'd0, 16'hfffe, 48'h0, 48'h0, 1'b0, 5'd0);
      // long receiver hold while requests keep coming
      hold_long = 1;
      repeat (40) random_request(1);
      for (int n = 0; n < 1500; n++) random_request(0);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
rtl/rsr_pkg.sv
rtl/rsr_row_store.sv
rtl/rsr_row_update.sv
rtl/rrip_ship_stream_replacement.sv
rtl/rsr_checker.sv
dv/rsr_checker.sv
dv/tb_top.sv
